/* sv/hkd_pkg.sv */
// Package: shared constants, codes and control types for the keypoint decoder.
`default_nettype none
package hkd_pkg;

  localparam int HM_WIDTH  = 48;
  localparam int HM_HEIGHT = 64;
  localparam int KEYPOINTS = 17;

  localparam int SCORE_W   = 16;
  localparam int COL_W     = (HM_WIDTH > 1) ? $clog2(HM_WIDTH) : 1;
  localparam int ROW_W     = (HM_HEIGHT > 1) ? $clog2(HM_HEIGHT) : 1;
  localparam int POS_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int HM_MAX    = (HM_WIDTH > HM_HEIGHT) ? HM_WIDTH : HM_HEIGHT;
  localparam int HM_SZ_W   = $clog2(HM_MAX + 1);
  localparam int LAYER_W   = 5;
  localparam int NET_W     = 11;
  localparam int SRC_W     = 14;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = NET_W + SRC_W;
  localparam int DIV_N_W   = PROD_W + 2;
  localparam int DIV_D_W   = NET_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Heatmap-to-network step: divide by 2*size through a reciprocal multiply.
  localparam int     MID_N_W    = POS_W + NET_W + 1;
  localparam int     RCP_SH     = MID_N_W + $clog2(2 * HM_MAX);
  localparam int     MID_P_W    = MID_N_W + RCP_SH;
  localparam longint RCP_WIDTH  =
    ((longint'(1) << RCP_SH) + 2 * HM_WIDTH - 1) / (2 * HM_WIDTH);
  localparam longint RCP_HEIGHT =
    ((longint'(1) << RCP_SH) + 2 * HM_HEIGHT - 1) / (2 * HM_HEIGHT);

  localparam logic [NET_W-1:0] NET_WIDTH_RST  = NET_W'(192);
  localparam logic [NET_W-1:0] NET_HEIGHT_RST = NET_W'(256);
  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = SRC_W'(1920);
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = SRC_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NET_WIDTH,
    CFG_NET_HEIGHT,
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_MUL1,
    ST_SCALE1,
    ST_MUL2,
    ST_START2,
    ST_DIV2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic prod_load;
    logic mid_load;
    logic div_start;
    logic step;
    logic axis;
    logic coord_store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic layer_end;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* sv/hkd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module hkd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hkd_pkg::DIV_N_W-1:0] num,
  input  logic [hkd_pkg::DIV_D_W-1:0] den,
  output logic [hkd_pkg::DIV_N_W-1:0] quo,
  output logic                        done
);

  logic [hkd_pkg::DIV_D_W-1:0]   rem;
  logic [hkd_pkg::DIV_D_W-1:0]   den_q;
  logic [hkd_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic [hkd_pkg::DIV_D_W:0]     rem_sh;
  logic [hkd_pkg::DIV_D_W:0]     diff;

  assign rem_sh = {rem, quo[hkd_pkg::DIV_N_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == hkd_pkg::DIV_CNT_W'(hkd_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      if (!diff[hkd_pkg::DIV_D_W]) begin
        rem <= diff[hkd_pkg::DIV_D_W-1:0];
        quo <= {quo[hkd_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[hkd_pkg::DIV_D_W-1:0];
        quo <= {quo[hkd_pkg::DIV_N_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* sv/hkd_datapath.sv */
// Datapath: argmax tracking, configuration registers, coordinate scaling, result register.
`default_nettype none
module hkd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  hkd_pkg::cmd_t                       cmd,
  output hkd_pkg::stat_t                      stat,
  input  logic signed [hkd_pkg::SCORE_W-1:0]  score,
  input  logic                                cfg_we,
  input  logic [hkd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hkd_pkg::CFG_W-1:0]           cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hkd_pkg::LAYER_W-1:0]         keypoint_index,
  output logic [hkd_pkg::SRC_W-1:0]           point_x,
  output logic [hkd_pkg::SRC_W-1:0]           point_y,
  output logic                                last_keypoint
);

  logic [hkd_pkg::NET_W-1:0]   net_width;
  logic [hkd_pkg::NET_W-1:0]   net_height;
  logic [hkd_pkg::SRC_W-1:0]   src_width;
  logic [hkd_pkg::SRC_W-1:0]   src_height;

  logic signed [hkd_pkg::SCORE_W-1:0] best_score;
  logic [hkd_pkg::COL_W-1:0]   best_col;
  logic [hkd_pkg::ROW_W-1:0]   best_row;
  logic [hkd_pkg::COL_W-1:0]   col_count;
  logic [hkd_pkg::ROW_W-1:0]   row_count;
  logic [hkd_pkg::LAYER_W-1:0] layer_count;

  logic [hkd_pkg::PROD_W-1:0]  prod;
  logic [hkd_pkg::NET_W-1:0]   nx;
  logic [hkd_pkg::SRC_W-1:0]   coord_x;
  logic [hkd_pkg::SRC_W-1:0]   coord_y;

  logic                        col_last;
  logic                        row_last;
  logic                        first;
  logic [hkd_pkg::POS_W-1:0]   pos_sel;
  logic [hkd_pkg::HM_SZ_W-1:0] hm_sel;
  logic [hkd_pkg::NET_W-1:0]   net_sel;
  logic [hkd_pkg::SRC_W-1:0]   src_sel;
  logic [hkd_pkg::RCP_SH-1:0]  rcp_sel;
  logic [hkd_pkg::MID_N_W-1:0] mid_num;
  logic [hkd_pkg::MID_P_W-1:0] mid_prod;
  logic [hkd_pkg::SRC_W-1:0]   coord_val;
  logic [hkd_pkg::DIV_N_W-1:0] div_num;
  logic [hkd_pkg::DIV_D_W-1:0] div_den;
  logic [hkd_pkg::DIV_N_W-1:0] div_quo;
  logic                        div_done;

  assign col_last = (col_count == hkd_pkg::COL_W'(hkd_pkg::HM_WIDTH - 1));
  assign row_last = (row_count == hkd_pkg::ROW_W'(hkd_pkg::HM_HEIGHT - 1));
  assign first    = (col_count == '0) && (row_count == '0);

  assign stat.layer_end = col_last && row_last;
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

  assign pos_sel = cmd.axis ? hkd_pkg::POS_W'(best_row) : hkd_pkg::POS_W'(best_col);
  assign hm_sel  = cmd.axis ? hkd_pkg::HM_SZ_W'(hkd_pkg::HM_HEIGHT)
                            : hkd_pkg::HM_SZ_W'(hkd_pkg::HM_WIDTH);
  assign net_sel = cmd.axis ? net_height : net_width;
  assign src_sel = cmd.axis ? src_height : src_width;
  assign rcp_sel = cmd.axis ? hkd_pkg::RCP_SH'(hkd_pkg::RCP_HEIGHT)
                            : hkd_pkg::RCP_SH'(hkd_pkg::RCP_WIDTH);

  assign mid_num  = hkd_pkg::MID_N_W'({prod, 1'b0}) + hkd_pkg::MID_N_W'(hm_sel);
  assign mid_prod = hkd_pkg::MID_P_W'(mid_num) * hkd_pkg::MID_P_W'(rcp_sel);

  assign coord_val = (net_sel == '0) ? '0 : div_quo[hkd_pkg::SRC_W-1:0];

  assign div_num = hkd_pkg::DIV_N_W'({prod, 1'b0}) + hkd_pkg::DIV_N_W'(net_sel);
  assign div_den = {net_sel, 1'b0};

  hkd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      layer_count <= '0;
      out_valid   <= 1'b0;
      net_width   <= hkd_pkg::NET_WIDTH_RST;
      net_height  <= hkd_pkg::NET_HEIGHT_RST;
      src_width   <= hkd_pkg::SRC_WIDTH_RST;
      src_height  <= hkd_pkg::SRC_HEIGHT_RST;
    end else begin
      if (cmd.accept) begin
        if (col_last) begin
          col_count <= '0;
          row_count <= row_last ? '0 : row_count + 1'b1;
        end else begin
          col_count <= col_count + 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid   <= 1'b1;
        layer_count <= (layer_count == hkd_pkg::LAYER_W'(hkd_pkg::KEYPOINTS - 1))
                       ? '0 : layer_count + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (hkd_pkg::cfg_idx_t'(cfg_index))
          hkd_pkg::CFG_NET_WIDTH:  net_width  <= cfg_data[hkd_pkg::NET_W-1:0];
          hkd_pkg::CFG_NET_HEIGHT: net_height <= cfg_data[hkd_pkg::NET_W-1:0];
          hkd_pkg::CFG_SRC_WIDTH:  src_width  <= cfg_data[hkd_pkg::SRC_W-1:0];
          hkd_pkg::CFG_SRC_HEIGHT: src_height <= cfg_data[hkd_pkg::SRC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (first || (score > best_score))) begin
      best_score <= score;
      best_col   <= col_count;
      best_row   <= row_count;
    end
    if (cmd.prod_load) begin
      if (cmd.step) begin
        prod <= hkd_pkg::PROD_W'(nx) * hkd_pkg::PROD_W'(src_sel);
      end else begin
        prod <= hkd_pkg::PROD_W'(pos_sel) * hkd_pkg::PROD_W'(net_sel);
      end
    end
    if (cmd.mid_load) begin
      nx <= mid_prod[hkd_pkg::RCP_SH +: hkd_pkg::NET_W];
    end
    if (cmd.coord_store) begin
      if (cmd.axis) begin
        coord_y <= coord_val;
      end else begin
        coord_x <= coord_val;
      end
    end
    if (cmd.emit) begin
      keypoint_index <= layer_count;
      point_x        <= coord_x;
      point_y        <= coord_y;
      last_keypoint  <= (layer_count == hkd_pkg::LAYER_W'(hkd_pkg::KEYPOINTS - 1));
    end
  end

endmodule
`default_nettype wire

/* sv/hkd_ctrl.sv */
// Controller: sequences score intake, the two scaling steps per axis and the result load.
`default_nettype none
module hkd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hkd_pkg::stat_t stat,
  output hkd_pkg::cmd_t  cmd
);

  hkd_pkg::state_t state;
  hkd_pkg::state_t state_next;
  logic            axis;
  logic            axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hkd_pkg::ST_SCAN;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next      = state;
    axis_next       = axis;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.axis        = axis;
    case (state)
      hkd_pkg::ST_SCAN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.layer_end) begin
          state_next = hkd_pkg::ST_MUL1;
        end
      end
      hkd_pkg::ST_MUL1: begin
        cmd.prod_load = 1'b1;
        state_next    = hkd_pkg::ST_SCALE1;
      end
      hkd_pkg::ST_SCALE1: begin
        cmd.mid_load = 1'b1;
        state_next   = hkd_pkg::ST_MUL2;
      end
      hkd_pkg::ST_MUL2: begin
        cmd.step      = 1'b1;
        cmd.prod_load = 1'b1;
        state_next    = hkd_pkg::ST_START2;
      end
      hkd_pkg::ST_START2: begin
        cmd.step      = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = hkd_pkg::ST_DIV2;
      end
      hkd_pkg::ST_DIV2: begin
        cmd.step = 1'b1;
        if (stat.div_done) begin
          cmd.coord_store = 1'b1;
          axis_next       = !axis;
          state_next      = axis ? hkd_pkg::ST_EMIT : hkd_pkg::ST_MUL1;
        end
      end
      hkd_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = hkd_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = hkd_pkg::ST_SCAN;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/heatmap_argmax_keypoint_decoder_top.sv */
// Top level of the heatmap argmax keypoint decoder.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid/in_ready   | score
//  output   | out_valid/out_ready | keypoint_index, point_x, point_y, last_keypoint
//  config   | cfg_we              | cfg_index, cfg_data
//
// One score beat per cycle within a layer. After the last score of a layer
// intake holds while, per axis, a multiply, a reciprocal multiply for the
// heatmap-to-network step and a 27-step divider for the network-to-source step
// run, and then the result is loaded into the output register.
// Synchronous active-high reset clears counters and output valid and loads the default configuration.
// A stalled output holds; intake resumes once the result is loaded.
`default_nettype none
module heatmap_argmax_keypoint_decoder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hkd_pkg::SCORE_W-1:0] score,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hkd_pkg::LAYER_W-1:0]        keypoint_index,
  output logic [hkd_pkg::SRC_W-1:0]          point_x,
  output logic [hkd_pkg::SRC_W-1:0]          point_y,
  output logic                               last_keypoint,
  input  logic                               cfg_we,
  input  logic [hkd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hkd_pkg::CFG_W-1:0]          cfg_data
);

  hkd_pkg::cmd_t  cmd;
  hkd_pkg::stat_t stat;

  hkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hkd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .score          (score),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .keypoint_index (keypoint_index),
    .point_x        (point_x),
    .point_y        (point_y),
    .last_keypoint  (last_keypoint)
  );

endmodule
`default_nettype wire

/* sv/hkd_checker.sv */
// Port checker for the keypoint decoder top level, with its bind.
`default_nettype none
module hkd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hkd_pkg::LAYER_W-1:0]   keypoint_index,
  input logic [hkd_pkg::SRC_W-1:0]     point_x,
  input logic [hkd_pkg::SRC_W-1:0]     point_y,
  input logic                          last_keypoint
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(keypoint_index) &&
      $stable(point_x) && $stable(point_y) && $stable(last_keypoint))
    else $error("output beat changed while stalled");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (last_keypoint == (keypoint_index == hkd_pkg::LAYER_W'(hkd_pkg::KEYPOINTS - 1))))
    else $error("last_keypoint disagrees with keypoint_index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (keypoint_index <= hkd_pkg::LAYER_W'(hkd_pkg::KEYPOINTS - 1)))
    else $error("keypoint_index out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind heatmap_argmax_keypoint_decoder_top hkd_checker u_hkd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .keypoint_index (keypoint_index),
  .point_x        (point_x),
  .point_y        (point_y),
  .last_keypoint  (last_keypoint)
);
`default_nettype wire
